// ===== hw/rtl/grdp_pkg.sv =====
`default_nettype none

package grdp_pkg;

	localparam int ALPHABET_MAX = 8;
	localparam int CHAR_W       = 8;
	localparam int IDX_W        = $clog2(ALPHABET_MAX);
	localparam int SIZE_W       = 4;
	localparam int ENC_W        = 7;
	localparam int DICT_DEPTH   = 3;
	localparam int CODE_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_CHARS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE  = 2'd1;

	// one packed byte's worth of results handed to the output stage
	typedef struct packed {
		logic                                row_end;
		logic [CHAR_W-1:0]                   data;
		logic [DICT_DEPTH-1:0][ENC_W-1:0]    ent;
		logic                                ovf;
	} grdp_batch_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grdp_lookup.sv =====
`default_nettype none

module grdp_lookup
	import grdp_pkg::*;
(
	input  wire logic [CFG_DATA_W-1:0] alphabet_chars,
	input  wire logic [SIZE_W-1:0]     alpha_count,
	input  wire logic [CHAR_W-1:0]     char_a,
	input  wire logic [CHAR_W-1:0]     char_b,
	output logic                       known,
	output logic [ENC_W-1:0]           enc
);

	logic [SIZE_W-1:0] size_c;
	logic              found_a;
	logic              found_b;
	logic [IDX_W-1:0]  idx_a;
	logic [IDX_W-1:0]  idx_b;
	logic [ENC_W-1:0]  prod;

	// clamp oversize alphabets
	assign size_c = (alpha_count > SIZE_W'(ALPHABET_MAX)) ? SIZE_W'(ALPHABET_MAX)
	                                                       : alpha_count;

	// parallel compare against every active alphabet slot (below the clamped size), highest index wins
	always_comb begin
		found_a = 1'b0;
		found_b = 1'b0;
		idx_a   = '0;
		idx_b   = '0;
		for (int k = 0; k < ALPHABET_MAX; k++) begin
			if (SIZE_W'(k) < size_c) begin
				if (alphabet_chars[CHAR_W*k +: CHAR_W] == char_a) begin
					found_a = 1'b1;
					idx_a   = IDX_W'(k);
				end
				if (alphabet_chars[CHAR_W*k +: CHAR_W] == char_b) begin
					found_b = 1'b1;
					idx_b   = IDX_W'(k);
				end
			end
		end
	end

	assign prod  = ENC_W'(idx_a) * ENC_W'(size_c);
	assign enc   = prod + ENC_W'(idx_b) + ENC_W'(1);
	assign known = found_a & found_b;

endmodule

`default_nettype wire

// ===== hw/rtl/grdp_dict.sv =====
`default_nettype none

module grdp_dict
	import grdp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             known,
	input  wire logic [ENC_W-1:0] enc,
	input  wire logic             row_end,
	output logic                  produces,
	output grdp_batch_t           batch
);

	logic [DICT_DEPTH-1:0][ENC_W-1:0] ent_q;
	logic [DICT_DEPTH-1:0][ENC_W-1:0] ent_next;
	logic [CODE_W-1:0]                used_q;
	logic [CHAR_W-1:0]                accum_q;
	logic [CHAR_W-1:0]                accum_next;
	logic [CODE_W-1:0]                slot_q;
	logic                             ovf_q;
	logic                             ovf_next;
	logic                             hit;
	logic                             add;
	logic [CODE_W-1:0]                hit_code;
	logic [CODE_W-1:0]                code;

	always_comb begin
		hit      = 1'b0;
		hit_code = '0;
		for (int i = 0; i < DICT_DEPTH; i++) begin
			if (CODE_W'(i) < used_q && ent_q[i] == enc) begin
				hit      = 1'b1;
				hit_code = CODE_W'(i + 1);
			end
		end
	end

	assign add      = known & ~hit & (used_q != CODE_W'(DICT_DEPTH));
	assign ovf_next = ovf_q | (known & ~hit & (used_q == CODE_W'(DICT_DEPTH)));

	always_comb begin
		code     = '0;
		ent_next = ent_q;
		if (known && hit) begin
			code = hit_code;
		end else if (add) begin
			code             = used_q + CODE_W'(1);
			ent_next[used_q] = enc;
		end
	end

	assign accum_next = accum_q | (CHAR_W'(code) << {slot_q, 1'b0});
	assign produces   = (slot_q == CODE_W'(3)) | row_end;

	// unused entries stay zero, so the headers read straight from the table
	assign batch = '{row_end: row_end, data: accum_next, ent: ent_next, ovf: ovf_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q   <= '0;
			used_q  <= '0;
			accum_q <= '0;
			slot_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (row_end) begin
				ent_q   <= '0;
				used_q  <= '0;
				accum_q <= '0;
				slot_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				ent_q  <= ent_next;
				used_q <= add ? used_q + CODE_W'(1) : used_q;
				ovf_q  <= ovf_next;
				if (slot_q == CODE_W'(3)) begin
					accum_q <= '0;
					slot_q  <= '0;
				end else begin
					accum_q <= accum_next;
					slot_q  <= slot_q + CODE_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/grdp_emit.sv =====
`default_nettype none

module grdp_emit
	import grdp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire grdp_batch_t batch,
	output logic             can_load,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [7:0]       out_value,
	output logic             out_last,
	output logic             dict_overflow
);

	logic             busy_q;
	logic [1:0]       pos_q;
	grdp_batch_t      b_q;
	logic             is_last;

	assign is_last  = (~b_q.row_end & (pos_q == 2'd0)) | (pos_q == 2'd3);
	assign can_load = ~busy_q | (out_ready & is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			b_q <= batch;
		end
	end

	always_comb begin
		case (pos_q)
			2'd0: begin
				out_kind  = 1'b0;
				out_value = b_q.data;
			end
			2'd1: begin
				out_kind  = 1'b1;
				out_value = 8'(b_q.ent[0]);
			end
			2'd2: begin
				out_kind  = 1'b1;
				out_value = 8'(b_q.ent[1]);
			end
			default: begin
				out_kind  = 1'b1;
				out_value = 8'(b_q.ent[2]);
			end
		endcase
	end

	assign out_valid     = busy_q;
	assign out_last      = b_q.row_end & (pos_q == 2'd3);
	assign dict_overflow = b_q.ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/genotype_row_dict_packer_core.sv =====
// Path: a genotype is registered in the input stage, its batch in the output stage.
// Throughput: one genotype per cycle while the output stage can take each batch; the
// row's last genotype holds the output for a data byte plus three header transfers.
// Reset: arst_n clears the dictionary, packing state, alphabet registers and
// all valid flags at once; no clearing pass is needed.
`default_nettype none

module genotype_row_dict_packer_core
	import grdp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CHAR_W-1:0]     allele_first,
	input  wire logic [CHAR_W-1:0]     allele_second,
	input  wire logic                  row_end,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_kind,
	output logic [7:0]                 out_value,
	output logic                       out_last,
	output logic                       dict_overflow
);

	// Configuration registers; write them only while the core is idle.
	logic [CFG_DATA_W-1:0] alphabet_chars_q;
	logic [SIZE_W-1:0]     alpha_count_q;

	// Input register stage.
	logic                  valid_s1;
	logic [CHAR_W-1:0]     first_s1;
	logic [CHAR_W-1:0]     second_s1;
	logic                  row_end_s1;

	logic                  known;
	logic [ENC_W-1:0]      enc;
	logic                  produces;
	logic                  can_load;
	logic                  step;
	logic                  load;
	grdp_batch_t           batch;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_chars_q <= '0;
			alpha_count_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ALPHABET_CHARS: alphabet_chars_q <= cfg_data;
				REG_ALPHABET_SIZE:  alpha_count_q    <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Retire the held item when it makes no result, or when the output stage
	// can take its batch; a genotype that fills no byte never waits on out_ready.
	assign step     = valid_s1 & (~produces | can_load);
	assign load     = step & produces;
	assign in_ready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input stage: hold until the next transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			first_s1   <= allele_first;
			second_s1  <= allele_second;
			row_end_s1 <= row_end;
		end
	end

	// Translate both characters and form the pair encoding.
	grdp_lookup u_lookup (
		.alphabet_chars (alphabet_chars_q),
		.alpha_count    (alpha_count_q),
		.char_a         (first_s1),
		.char_b         (second_s1),
		.known          (known),
		.enc            (enc)
	);

	// Per-row dictionary and 2-bit code packer; advances once per retired item.
	grdp_dict u_dict (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.known    (known),
		.enc      (enc),
		.row_end  (row_end_s1),
		.produces (produces),
		.batch    (batch)
	);

	// Result register: drain a batch one transfer at a time.
	grdp_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.batch         (batch),
		.can_load      (can_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind),
		.out_value     (out_value),
		.out_last      (out_last),
		.dict_overflow (dict_overflow)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/grdp_checker.sv =====
`default_nettype none

module grdp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_kind,
	input wire logic [7:0] out_value,
	input wire logic       out_last,
	input wire logic       dict_overflow
);

	// the row's final transfer is a header entry
	a_last_is_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_kind)
		else $error("last transfer is not a header entry");

	// header entries come as an unbroken run of three
	a_header_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind && !out_last |=> out_valid && out_kind)
		else $error("header run broken");

	// after the final header a new row starts with a data byte
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !(out_valid && out_kind))
		else $error("header follows end of row");

	// overflow flag is constant across a row's headers
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_kind && !out_last |=> $stable(dict_overflow))
		else $error("overflow flag changed within headers");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_kind))
		else $error("stalled result changed");

endmodule

bind genotype_row_dict_packer_core grdp_checker u_grdp_checker (.*);

`default_nettype wire
